// ----- rtl/erfs_pkg.sv -----
// Shared constants, types and command/status structs of the edge-renormalising FIR smoother.
package erfs_pkg;

  localparam int MaxTaps    = 5;
  localparam int SampleBits = 16;
  localparam int WeightBits = 16;
  localparam int CntBits    = 3;   // holds 0..MaxTaps
  localparam int KBits      = 3;   // tap index 0..MaxTaps-1
  localparam int HBits      = 2;   // half window 0..(MaxTaps-1)/2
  localparam int AgeBits    = 5;   // signed window age
  localparam int ProdBits   = SampleBits + WeightBits + 1;
  localparam int AccBits    = 36;
  localparam int MagBits    = 35;
  localparam int LoBits     = 18;
  localparam int HiBits     = MagBits - LoBits;
  localparam int FullBits   = 19;
  localparam int NumBits    = 54;
  localparam int QuoBits    = 17;
  localparam int RemBits    = 2 * FullBits - 1 + QuoBits - FullBits + 2; // 37
  localparam int DcntBits   = 5;
  localparam int IdxBits    = 3;
  localparam int DataBits   = 16;

  // Register indexes
  localparam logic [IdxBits-1:0] RegTapCount  = 3'd0;
  localparam logic [IdxBits-1:0] RegNormalize = 3'd1;
  localparam logic [IdxBits-1:0] RegWeight0   = 3'd2;
  localparam logic [IdxBits-1:0] RegWeight4   = 3'd6;

  localparam logic [CntBits-1:0] TapReset = 3'd5;
  localparam logic [MaxTaps-1:0][WeightBits-1:0] WeightReset =
    {16'd1, 16'd4, 16'd6, 16'd4, 16'd1};

  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StCheck   = 9'b000000010,
    StMac     = 9'b000000100,
    StMulLo   = 9'b000001000,
    StMulHi   = 9'b000010000,
    StDivInit = 9'b000100000,
    StDiv     = 9'b001000000,
    StResult  = 9'b010000000,
    StOut     = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [CntBits-1:0]                    tap_count;
    logic                                  normalize;
    logic [MaxTaps-1:0][WeightBits-1:0]    weight;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mac_init;
    logic mac_step;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic result;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic               emit_due;
    logic               mac_last;
    logic               div_last;
    logic [CntBits-1:0] pend;
  } status_t;

endpackage

// ----- rtl/erfs_if.sv -----
// Stream and configuration channel interfaces.
interface erfs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [erfs_pkg::SampleBits-1:0] sample;
  logic                                   end_of_stream;
  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface erfs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [erfs_pkg::SampleBits-1:0] smoothed;
  logic                                   last_of_run;
  modport source (output valid, smoothed, last_of_run, input ready);
  modport sink   (input valid, smoothed, last_of_run, output ready);
endinterface

interface erfs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [erfs_pkg::IdxBits-1:0]        index;
  logic [erfs_pkg::DataBits-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/erfs_ctrl.sv -----
// Sequencer: steps the datapath through accept, MAC, scale, divide and output.
module erfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  erfs_pkg::status_t  status_i,
  output erfs_pkg::cmd_t     cmd_o
);

  erfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= erfs_pkg::StIdle;
    else         state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      erfs_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = erfs_pkg::StCheck;
        end
      end
      erfs_pkg::StCheck: begin
        if (status_i.emit_due) begin
          cmd_o.mac_init = 1'b1;
          state_d        = erfs_pkg::StMac;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = erfs_pkg::StIdle;
        end
      end
      erfs_pkg::StMac: begin
        cmd_o.mac_step = 1'b1;
        if (status_i.mac_last) state_d = erfs_pkg::StMulLo;
      end
      erfs_pkg::StMulLo: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = erfs_pkg::StMulHi;
      end
      erfs_pkg::StMulHi: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = erfs_pkg::StDivInit;
      end
      erfs_pkg::StDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = erfs_pkg::StDiv;
      end
      erfs_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = erfs_pkg::StResult;
      end
      erfs_pkg::StResult: begin
        cmd_o.result = 1'b1;
        state_d      = erfs_pkg::StOut;
      end
      erfs_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          state_d   = erfs_pkg::StCheck;
        end
      end
      default: state_d = erfs_pkg::StIdle;
    endcase
  end

endmodule

// ----- rtl/erfs_dp.sv -----
// Datapath: sample window, MAC over the taps, gain scaling, restoring divider, saturation.
module erfs_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  erfs_pkg::cfg_t                         cfg_i,
  input  erfs_pkg::cmd_t                         cmd_i,
  input  logic signed [erfs_pkg::SampleBits-1:0] sample_i,
  input  logic                                   end_of_stream_i,
  output erfs_pkg::status_t                      status_o,
  output logic signed [erfs_pkg::SampleBits-1:0] smoothed_o,
  output logic                                   last_of_run_o
);

  localparam int SB = erfs_pkg::SampleBits;
  localparam logic [erfs_pkg::QuoBits-1:0] MaxPos = erfs_pkg::QuoBits'(2 ** (SB - 1) - 1);
  localparam logic [erfs_pkg::QuoBits-1:0] MaxNeg = erfs_pkg::QuoBits'(2 ** (SB - 1));

  logic signed [SB-1:0]                window_q [erfs_pkg::MaxTaps];
  logic [erfs_pkg::CntBits-1:0]        seen_q, pend_q;
  logic                                end_q;
  logic [erfs_pkg::KBits-1:0]          k_q;
  logic signed [erfs_pkg::AccBits-1:0] acc_q;
  logic [erfs_pkg::FullBits-1:0]       full_q, drop_q, den_q;
  logic [erfs_pkg::NumBits-1:0]        num_q;
  logic [erfs_pkg::RemBits-1:0]        rem_q, dsh_q;
  logic [erfs_pkg::QuoBits-1:0]        quo_q;
  logic [erfs_pkg::DcntBits-1:0]       dcnt_q;
  logic                                neg_q, ovf_q, zero_q;
  logic signed [SB-1:0]                smoothed_q;
  logic                                last_q;

  // taps in use and the half window
  logic [erfs_pkg::CntBits-1:0] taps;
  logic [erfs_pkg::HBits-1:0]   half;
  logic [erfs_pkg::CntBits-1:0] taps_m1, ctr;
  always_comb begin
    if (cfg_i.tap_count == '0) taps = erfs_pkg::CntBits'(1);
    else if (cfg_i.tap_count > erfs_pkg::CntBits'(erfs_pkg::MaxTaps))
      taps = erfs_pkg::CntBits'(erfs_pkg::MaxTaps);
    else taps = cfg_i.tap_count;
    taps_m1 = taps - 1'b1;
    half    = taps_m1[erfs_pkg::HBits:1];
    ctr     = pend_q - 1'b1;
  end

  // tap selection for the current MAC step
  logic signed [erfs_pkg::AgeBits-1:0] age;
  logic                                tap_ok;
  logic [erfs_pkg::KBits-1:0]          age_idx;
  logic [erfs_pkg::WeightBits-1:0]     wsel;
  logic signed [SB-1:0]                ssel;
  logic signed [erfs_pkg::ProdBits-1:0] prod;
  always_comb begin
    age = $signed({2'b00, ctr}) + $signed({3'b000, half}) - $signed({2'b00, k_q});
    tap_ok = (k_q <= {half, 1'b0}) && (age >= 0) && (age < $signed({2'b00, seen_q}));
    age_idx = (age[2:0] < erfs_pkg::KBits'(erfs_pkg::MaxTaps)) ? age[2:0] : '0;
    wsel = cfg_i.weight[k_q];
    ssel = window_q[age_idx];
    prod = $signed({1'b0, wsel}) * ssel;
  end

  // scaling and division operands
  logic [erfs_pkg::AccBits-1:0]   acc_neg;
  logic [erfs_pkg::MagBits-1:0]   mag;
  logic [erfs_pkg::FullBits-1:0]  mulv;
  logic [erfs_pkg::LoBits+erfs_pkg::FullBits-1:0] lo_prod;
  logic [erfs_pkg::HiBits+erfs_pkg::FullBits-1:0] hi_prod;
  logic [erfs_pkg::NumBits+1:0]   n2;
  logic [erfs_pkg::FullBits:0]    d2;
  logic [erfs_pkg::NumBits+1:0]   lim;
  logic [erfs_pkg::QuoBits-1:0]   quo_neg;
  always_comb begin
    acc_neg = -acc_q;
    mag     = acc_q[erfs_pkg::AccBits-1] ? acc_neg[erfs_pkg::MagBits-1:0]
                                         : acc_q[erfs_pkg::MagBits-1:0];
    mulv    = cfg_i.normalize ? erfs_pkg::FullBits'(1) : full_q;
    // split product at full width: low and high halves of the magnitude
    lo_prod = mag[erfs_pkg::LoBits-1:0] * mulv;
    hi_prod = mag[erfs_pkg::MagBits-1:erfs_pkg::LoBits] * mulv;
    n2      = {1'b0, num_q, 1'b0} + (erfs_pkg::NumBits+2)'(den_q);
    d2      = {den_q, 1'b0};
    lim     = (erfs_pkg::NumBits+2)'({d2, {erfs_pkg::QuoBits{1'b0}}});
    quo_neg = -quo_q;
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < erfs_pkg::MaxTaps; i++) window_q[i] <= '0;
      seen_q <= '0;
      pend_q <= '0;
      end_q  <= 1'b0;
    end else if (cmd_i.load) begin
      for (int i = erfs_pkg::MaxTaps - 1; i > 0; i--) window_q[i] <= window_q[i-1];
      window_q[0] <= sample_i;
      if (seen_q < erfs_pkg::CntBits'(erfs_pkg::MaxTaps)) seen_q <= seen_q + 1'b1;
      if (pend_q < erfs_pkg::CntBits'(erfs_pkg::MaxTaps)) pend_q <= pend_q + 1'b1;
      end_q <= end_of_stream_i;
    end else if (cmd_i.pop) begin
      pend_q <= pend_q - 1'b1;
    end else if (cmd_i.finish && end_q) begin
      for (int i = 0; i < erfs_pkg::MaxTaps; i++) window_q[i] <= '0;
      seen_q <= '0;
      end_q  <= 1'b0;
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_init) begin
      k_q    <= '0;
      acc_q  <= '0;
      full_q <= '0;
      drop_q <= '0;
    end
    if (cmd_i.mac_step) begin
      k_q    <= k_q + 1'b1;
      full_q <= full_q + erfs_pkg::FullBits'(wsel);
      if (tap_ok) acc_q <= acc_q + erfs_pkg::AccBits'(prod);
      else if (k_q <= {half, 1'b0}) drop_q <= drop_q + erfs_pkg::FullBits'(wsel);
    end
    if (cmd_i.mul_lo) begin
      num_q <= erfs_pkg::NumBits'(lo_prod);
      den_q <= full_q - drop_q;
      neg_q <= acc_q[erfs_pkg::AccBits-1];
    end
    if (cmd_i.mul_hi) begin
      num_q <= num_q + erfs_pkg::NumBits'({hi_prod, {erfs_pkg::LoBits{1'b0}}});
    end
    if (cmd_i.div_init) begin
      ovf_q  <= n2 >= lim;
      zero_q <= den_q == '0;
      rem_q  <= n2[erfs_pkg::RemBits-1:0];
      dsh_q  <= erfs_pkg::RemBits'({d2, {(erfs_pkg::QuoBits-1){1'b0}}});
      quo_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dsh_q) begin
        rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[erfs_pkg::QuoBits-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[erfs_pkg::QuoBits-2:0], 1'b0};
      end
      dsh_q  <= dsh_q >> 1;
      dcnt_q <= dcnt_q + 1'b1;
    end
    // round-to-nearest quotient, saturated
    if (cmd_i.result) begin
      if (zero_q) smoothed_q <= '0;
      else if (!neg_q) begin
        if (ovf_q || quo_q > MaxPos) smoothed_q <= $signed(MaxPos[SB-1:0]);
        else                         smoothed_q <= $signed(quo_q[SB-1:0]);
      end else begin
        if (ovf_q || quo_q > MaxNeg) smoothed_q <= $signed(MaxNeg[SB-1:0]);
        else                         smoothed_q <= $signed(quo_neg[SB-1:0]);
      end
      last_q <= end_q && (pend_q == erfs_pkg::CntBits'(1));
    end
  end

  always_comb begin
    status_o.emit_due = (pend_q != '0) && (end_q || (pend_q > erfs_pkg::CntBits'(half)));
    status_o.mac_last = k_q == taps_m1;
    status_o.div_last = dcnt_q == erfs_pkg::DcntBits'(erfs_pkg::QuoBits - 1);
    status_o.pend     = pend_q;
  end

  assign smoothed_o    = smoothed_q;
  assign last_of_run_o = last_q;

endmodule

// ----- rtl/edge_renormalized_fir_smoother.sv -----
// Top level of the streaming FIR smoother with edge weight renormalisation.
//
// Channels: in_i carries sample beats (sample, end_of_stream), out_o carries
// result beats (smoothed, last_of_run), cfg_i writes one register per beat:
// index 0 tap_count, 1 normalize_mode, 2..6 weight_0..weight_4. cfg_i is
// always ready; write only while the block is idle.
// One input beat is taken at a time. After acceptance the block works out
// every output that beat releases (none, one, or on end_of_stream all those
// owed), each by a MAC pass over the taps in use on one multiplier, a low
// and a high scaling step, a divider set-up step, 17 restoring divider
// steps and a rounding/saturation step, then the beat is held on out_o.
// A beat that releases nothing returns the block straight to idle.
// When the receiver stalls, the result stays in the output register and the
// block waits; no input is taken meanwhile.
// Reset clears the window and the seen/pending counters and sets tap_count 5,
// normalise on, weights 1,4,6,4,1; no clearing pass is needed.
module edge_renormalized_fir_smoother (
  input  logic       clk_i,
  input  logic       rst_ni,
  erfs_in_if.sink    in_i,
  erfs_out_if.source out_o,
  erfs_cfg_if.sink   cfg_i
);

  erfs_pkg::cfg_t    cfg_q;
  erfs_pkg::cmd_t    cmd;
  erfs_pkg::status_t status;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_count <= erfs_pkg::TapReset;
      cfg_q.normalize <= 1'b1;
      cfg_q.weight    <= erfs_pkg::WeightReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == erfs_pkg::RegTapCount)
        cfg_q.tap_count <= cfg_i.data[erfs_pkg::CntBits-1:0];
      else if (cfg_i.index == erfs_pkg::RegNormalize)
        cfg_q.normalize <= cfg_i.data[0];
      else if (cfg_i.index >= erfs_pkg::RegWeight0 && cfg_i.index <= erfs_pkg::RegWeight4)
        cfg_q.weight[cfg_i.index - erfs_pkg::RegWeight0] <= cfg_i.data;
    end
  end

  erfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  erfs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sample_i        (in_i.sample),
    .end_of_stream_i (in_i.end_of_stream),
    .status_o        (status),
    .smoothed_o      (out_o.smoothed),
    .last_of_run_o   (out_o.last_of_run)
  );

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input and output active together");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("accepted beat while busy");
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pend <= erfs_pkg::CntBits'(erfs_pkg::MaxTaps)) else $error("pending count overrun");
  a_out_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> status.pend != '0) else $error("output with nothing pending");

endmodule
